/* hdl/itce_pkg.sv */
// Package for the IPv4/TCP checksum engine: constants, the finished-packet
// record and the ones'-complement add. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itce_pkg;

  localparam logic [15:0] WordMax     = 16'hFFFF;
  localparam logic [7:0]  ProtoTcp    = 8'd6;
  localparam logic [15:0] IpCkWord    = 16'd5;
  localparam logic [15:0] PseudoFirst = 16'd6;
  localparam logic [15:0] PseudoLast  = 16'd9;
  localparam logic [5:0]  TcpCkOffset = 6'd8;
  localparam logic [3:0]  MinIhl      = 4'd5;

  // Packet state captured on the last word, after that word is summed.
  typedef struct packed {
    logic [15:0] tcp_sum;
    logic [15:0] ip_sum;
    logic [15:0] word_count;
    logic [15:0] total_bytes;
    logic [3:0]  header_words;
    logic        proto_tcp;
  } fin_t;

  // 16-bit ones'-complement add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

/* hdl/ipv4_tcp_checksum_engine_top.sv */
// IPv4/TCP checksum engine top level: finish stage and output register.
// Depends on itce_pkg and itce_accum.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one IPv4 packet as big-endian
//   16-bit words, in_last_word set on the final word. One request per cycle
//   is taken while in_ready is high; no gaps are needed between packets.
//   Output channel (out_valid/out_ready) carries one request per packet:
//   both complemented checksums plus is_tcp, short_packet and malformed.
//   Result path: the last word is summed into the finish register, then the
//   pseudo-header tail add, complement and checks go into the output
//   register; a full output register can hold the finish register between
//   them. Throughput: one word per cycle while in_ready is high, set by the
//   single ones'-complement add per sum on each word.
//   Stall: a held result stalls the finish register; in_ready drops only
//   when both the finish register and the output register are full.
//   Reset (rst_n low, synchronous) clears all sums, counters and valids.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_tcp_checksum_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [15:0] in_data_word,
  input  wire logic        in_last_word,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [15:0] out_tcp_checksum,
  output      logic [15:0] out_ip_checksum,
  output      logic        out_is_tcp,
  output      logic        out_short_packet,
  output      logic        out_malformed
);

  itce_pkg::fin_t fin;
  itce_pkg::fin_t fin_r;
  logic           fin_v_r;
  logic           out_v_r;
  logic           accept;
  logic           out_adv;

  logic [15:0] tcp_len;
  logic [15:0] tcp_sum1;
  logic [15:0] tcp_sum2;
  logic        is_short;
  logic        bad;
  logic        ok;

  logic [15:0] tcp_ck_r, tcp_ck_nxt;
  logic [15:0] ip_ck_r, ip_ck_nxt;
  logic        is_tcp_r, is_tcp_nxt;
  logic        short_r, short_nxt;
  logic        bad_r, bad_nxt;

  assign out_adv  = fin_v_r && (!out_v_r || out_ready);
  assign in_ready = !fin_v_r || out_adv;
  assign accept   = in_valid && in_ready;

  itce_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_word (in_data_word),
    .last_word (in_last_word),
    .fin       (fin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (accept && in_last_word) begin
      fin_v_r <= 1'b1;
    end else if (out_adv) begin
      fin_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last_word) begin
      fin_r <= fin;
    end
  end

  // Finish: pseudo-header tail, checks, complement.
  always_comb begin
    tcp_len  = fin_r.total_bytes - {10'd0, fin_r.header_words, 2'b00};
    tcp_sum1 = itce_pkg::oc_add(fin_r.tcp_sum, tcp_len);
    tcp_sum2 = itce_pkg::oc_add(tcp_sum1, {8'd0, itce_pkg::ProtoTcp});
    is_short = (fin_r.word_count < 16'd2)
            || ({fin_r.word_count, 1'b0} < {1'b0, fin_r.total_bytes});
    bad      = (fin_r.header_words < itce_pkg::MinIhl)
            || (fin_r.total_bytes < {10'd0, fin_r.header_words, 2'b00});
    ok       = fin_r.proto_tcp && !is_short && !bad;

    tcp_ck_nxt = ok ? ~tcp_sum2 : 16'd0;
    ip_ck_nxt  = ok ? ~fin_r.ip_sum : 16'd0;
    is_tcp_nxt = ok;
    short_nxt  = is_short;
    bad_nxt    = bad;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      tcp_ck_r <= tcp_ck_nxt;
      ip_ck_r  <= ip_ck_nxt;
      is_tcp_r <= is_tcp_nxt;
      short_r  <= short_nxt;
      bad_r    <= bad_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_tcp_checksum = tcp_ck_r;
  assign out_ip_checksum  = ip_ck_r;
  assign out_is_tcp       = is_tcp_r;
  assign out_short_packet = short_r;
  assign out_malformed    = bad_r;

`ifndef SYNTH
  a_tcp_excl_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_tcp |-> !out_short_packet && !out_malformed)
    else $error("is_tcp set together with an error flag");

  a_zero_ck: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_tcp |-> out_tcp_checksum == 16'd0 && out_ip_checksum == 16'd0)
    else $error("checksums not zero on a non-TCP result");

  a_last_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last_word |=> fin_v_r)
    else $error("last word did not load the finish register");

  a_fin_drain: assert property (@(posedge clk) disable iff (!rst_n)
    fin_v_r && !out_v_r |=> out_v_r)
    else $error("finished packet did not move to the output register");
`endif

endmodule

`default_nettype wire

/* hdl/itce_accum.sv */
// Per-word header parse and running IP/TCP ones'-complement sums.
// Depends on itce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itce_accum (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [15:0]   data_word,
  input  wire logic          last_word,
  output itce_pkg::fin_t     fin
);

  logic [15:0] word_count_r, word_count_nxt;
  logic [3:0]  header_words_r, header_words_nxt;
  logic [15:0] total_bytes_r, total_bytes_nxt;
  logic        proto_tcp_r, proto_tcp_nxt;
  logic [15:0] ip_acc_r, ip_acc_nxt;
  logic [15:0] tcp_acc_r, tcp_acc_nxt;

  logic [4:0]  hdr_lim;
  logic [5:0]  tcp_ck_idx;
  logic        in_hdr;
  logic        in_seg;
  logic [15:0] ip_val;
  logic [15:0] tcp_val;
  logic [15:0] seg_val;

  always_comb begin
    header_words_nxt = (word_count_r == 16'd0) ? data_word[11:8] : header_words_r;
    total_bytes_nxt  = (word_count_r == 16'd1) ? data_word : total_bytes_r;
    proto_tcp_nxt    = (word_count_r == 16'd4) ? (data_word[7:0] == itce_pkg::ProtoTcp)
                                               : proto_tcp_r;

    hdr_lim    = {header_words_nxt, 1'b0};
    tcp_ck_idx = {1'b0, hdr_lim} + itce_pkg::TcpCkOffset;
    in_hdr     = word_count_r < {11'd0, hdr_lim};
    in_seg     = {word_count_r, 1'b0} < {1'b0, total_bytes_nxt};

    seg_val = data_word;
    if ({word_count_r, 1'b1} == {1'b0, total_bytes_nxt}) begin
      seg_val[7:0] = 8'd0;
    end
    if (word_count_r == {10'd0, tcp_ck_idx}) begin
      seg_val = 16'd0;
    end

    ip_val  = 16'd0;
    tcp_val = 16'd0;
    if (in_hdr) begin
      if (word_count_r != itce_pkg::IpCkWord) begin
        ip_val = data_word;
      end
      if (word_count_r >= itce_pkg::PseudoFirst && word_count_r <= itce_pkg::PseudoLast) begin
        tcp_val = data_word;
      end
    end else if (in_seg) begin
      tcp_val = seg_val;
    end

    ip_acc_nxt     = itce_pkg::oc_add(ip_acc_r, ip_val);
    tcp_acc_nxt    = itce_pkg::oc_add(tcp_acc_r, tcp_val);
    word_count_nxt = (word_count_r == itce_pkg::WordMax) ? word_count_r
                                                         : word_count_r + 16'd1;

    fin.tcp_sum      = tcp_acc_nxt;
    fin.ip_sum       = ip_acc_nxt;
    fin.word_count   = word_count_nxt;
    fin.total_bytes  = total_bytes_nxt;
    fin.header_words = header_words_nxt;
    fin.proto_tcp    = proto_tcp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_word)) begin
      word_count_r   <= 16'd0;
      header_words_r <= 4'd0;
      total_bytes_r  <= 16'd0;
      proto_tcp_r    <= 1'b0;
      ip_acc_r       <= 16'd0;
      tcp_acc_r      <= 16'd0;
    end else if (accept) begin
      word_count_r   <= word_count_nxt;
      header_words_r <= header_words_nxt;
      total_bytes_r  <= total_bytes_nxt;
      proto_tcp_r    <= proto_tcp_nxt;
      ip_acc_r       <= ip_acc_nxt;
      tcp_acc_r      <= tcp_acc_nxt;
    end
  end

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Testbench for ipv4_tcp_checksum_engine_top: streams IPv4 packets word by word
// and checks each per-packet checksum request against an in-bench predictor.
// Depends on itce_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int StallLimit = 500;
  localparam int RandomWords = 1200;
  localparam int BurstWords = 200;

  typedef struct {
    logic [15:0] tcp_ck;
    logic [15:0] ip_ck;
    logic        is_tcp;
    logic        short_pkt;
    logic        bad_hdr;
  } cksum_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_data_word;
  logic        in_last_word;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_tcp_checksum;
  logic [15:0] out_ip_checksum;
  logic        out_is_tcp;
  logic        out_short_packet;
  logic        out_malformed;

  // predictor state for the packet in flight
  logic [15:0] pkt_words;
  logic [3:0]  pkt_ihl;
  logic [15:0] pkt_total;
  logic        pkt_proto_tcp;
  logic [15:0] ip_sum;
  logic [15:0] tcp_sum;

  cksum_t expected_sums[$];
  int errors;
  int words_sent;
  int packets_sent;
  int tcp_results;
  int error_results;
  int stall_cycles;
  bit src_idle;
  bit sink_idle;

  ipv4_tcp_checksum_engine_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_word(in_data_word),
    .in_last_word(in_last_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tcp_checksum(out_tcp_checksum),
    .out_ip_checksum(out_ip_checksum),
    .out_is_tcp(out_is_tcp),
    .out_short_packet(out_short_packet),
    .out_malformed(out_malformed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    int unsigned t;
    t = int'(a) + int'(b);
    return 16'(t & 32'hFFFF) + 16'(t >> 16);
  endfunction

  function automatic void clear_packet();
    pkt_words = '0;
    pkt_ihl = '0;
    pkt_total = '0;
    pkt_proto_tcp = 1'b0;
    ip_sum = '0;
    tcp_sum = '0;
  endfunction

  // Advance the predictor by one accepted word; queue a result on the last one.
  function automatic void track_word(input logic [15:0] d, input logic lst);
    int unsigned w;
    int unsigned lim;
    logic [15:0] v;
    logic [15:0] seg_len;
    logic [15:0] tsum;
    cksum_t r;
    bit short_pkt;
    bit bad_hdr;
    bit ok;

    w = pkt_words;
    if (w == 0) pkt_ihl = d[11:8];
    else if (w == 1) pkt_total = d;
    else if (w == 4) pkt_proto_tcp = (d[7:0] == itce_pkg::ProtoTcp);

    lim = 2 * int'(pkt_ihl);
    if (w < lim) begin
      if (w != itce_pkg::IpCkWord) ip_sum = fold_add(ip_sum, d);
      if (w >= itce_pkg::PseudoFirst && w <= itce_pkg::PseudoLast) begin
        tcp_sum = fold_add(tcp_sum, d);
      end
    end else if (2 * w < int'(pkt_total)) begin
      v = d;
      if (2 * w + 1 == int'(pkt_total)) v[7:0] = 8'h00;
      if (w == lim + itce_pkg::TcpCkOffset) v = '0;
      tcp_sum = fold_add(tcp_sum, v);
    end
    if (pkt_words != itce_pkg::WordMax) pkt_words = pkt_words + 16'd1;

    if (lst) begin
      short_pkt = (pkt_words < 2) || (2 * int'(pkt_words) < int'(pkt_total));
      bad_hdr = (pkt_ihl < itce_pkg::MinIhl) || (int'(pkt_total) < 4 * int'(pkt_ihl));
      ok = pkt_proto_tcp && !short_pkt && !bad_hdr;
      seg_len = pkt_total - {10'd0, pkt_ihl, 2'b00};
      tsum = fold_add(fold_add(tcp_sum, seg_len), {8'd0, itce_pkg::ProtoTcp});
      r.tcp_ck = ok ? ~tsum : 16'd0;
      r.ip_ck = ok ? ~ip_sum : 16'd0;
      r.is_tcp = ok;
      r.short_pkt = short_pkt;
      r.bad_hdr = bad_hdr;
      expected_sums.push_back(r);
      packets_sent++;
      if (ok) tcp_results++;
      if (short_pkt || bad_hdr) error_results++;
      clear_packet();
    end
  endfunction

  task automatic send_word(input logic [15:0] d, input logic lst);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_word <= d;
    in_last_word <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_word(d, lst);
    words_sent++;
  endtask

  // Header fields go in place; everything else is random.
  task automatic send_packet(input int ihl, input int tot, input int proto, input int nwords);
    logic [15:0] w;
    for (int i = 0; i < nwords; i++) begin
      w = 16'($urandom);
      if (i == 0) w[11:8] = 4'(ihl);
      else if (i == 1) w = 16'(tot);
      else if (i == 4) w[7:0] = 8'(proto);
      send_word(w, i == nwords - 1);
    end
  endtask

  task automatic test_directed();
    src_idle = 1'b1;
    sink_idle = 1'b1;
    send_word(16'h0000, 1'b1);
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b1);
    // odd length TCP with one trailing word past the total length
    send_packet(5, 21, itce_pkg::ProtoTcp, 12);
    // non-TCP, total length below the header length
    send_packet(6, 20, 17, 10);
  endtask

  task automatic random_packet();
    int r;
    int ihl;
    int tot;
    int proto;
    int nwords;
    r = $urandom_range(0, 99);
    ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
    tot = 4 * ihl + $urandom_range(0, 48);
    proto = itce_pkg::ProtoTcp;
    nwords = (tot + 1) / 2;
    if (r < 10) begin
      proto = $urandom_range(0, 255);
    end else if (r < 20) begin
      nwords = $urandom_range(1, nwords - 1);
    end else if (r < 28) begin
      ihl = $urandom_range(0, 4);
    end else if (r < 34) begin
      tot = $urandom_range(0, 4 * ihl - 1);
      nwords = $urandom_range(1, 2 * ihl + 2);
    end else if (r < 40) begin
      tot = $urandom_range(0, 65535);
      nwords = $urandom_range(1, 8);
    end
    if (r >= 90) nwords += $urandom_range(1, 4);
    send_packet(ihl, tot, proto, nwords);
  endtask

  task automatic test_random_traffic();
    int start;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    start = words_sent;
    while (words_sent - start < RandomWords) random_packet();
  endtask

  // no idling on either side; tiny packets mixed in to back up the output
  task automatic test_back_to_back();
    int start;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    start = words_sent;
    while (words_sent - start < BurstWords) begin
      if ($urandom_range(0, 3) == 0) send_packet($urandom_range(0, 15), $urandom, 6, 1);
      else random_packet();
    end
  endtask

  task automatic finish_run();
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    errors += expected_sums.size();
    $display("covered %0d packets in %0d words: %0d valid TCP, %0d short or malformed",
             packets_sent, words_sent, tcp_results, error_results);
    $display("includes directed edges, random packets with stalls and a no-idle burst");
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  endtask

  initial begin
    out_ready = 1'b1;
    forever begin
      @(posedge clk);
      if (sink_idle && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cksum_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected checksum request: tcp=%h ip=%h",
                                   out_tcp_checksum, out_ip_checksum);
      end else begin
        e = expected_sums.pop_front();
        if (out_tcp_checksum !== e.tcp_ck || out_ip_checksum !== e.ip_ck ||
            out_is_tcp !== e.is_tcp || out_short_packet !== e.short_pkt ||
            out_malformed !== e.bad_hdr) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: got tcp=%h ip=%h is_tcp=%b short=%b malformed=%b",
                     out_tcp_checksum, out_ip_checksum, out_is_tcp, out_short_packet,
                     out_malformed);
            $display("          exp tcp=%h ip=%h is_tcp=%b short=%b malformed=%b",
                     e.tcp_ck, e.ip_ck, e.is_tcp, e.short_pkt, e.bad_hdr);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("timeout: no request moved for %0d cycles", StallLimit);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_word = '0;
    in_last_word = 1'b0;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    errors = 0;
    words_sent = 0;
    packets_sent = 0;
    tcp_results = 0;
    error_results = 0;
    stall_cycles = 0;
    clear_packet();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic();
    test_back_to_back();
    in_valid <= 1'b0;
    finish_run();
  end

endmodule
